// ----- src/ect_pkg.sv -----
// Shared types and codes for the expression character tokenizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ect_pkg;

  // Width of the internal character position counter.
  localparam int POS_BITS = 16;
  // Fixed field widths of a result item.
  localparam int KIND_W = 4;
  localparam int FPOS_W = 16;
  localparam int ERR_W  = 2;

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_PLUS   = 4'd0;
  localparam logic [KIND_W-1:0] K_MINUS  = 4'd1;
  localparam logic [KIND_W-1:0] K_STAR   = 4'd2;
  localparam logic [KIND_W-1:0] K_SLASH  = 4'd3;
  localparam logic [KIND_W-1:0] K_CARET  = 4'd4;
  localparam logic [KIND_W-1:0] K_NUMBER = 4'd5;
  localparam logic [KIND_W-1:0] K_LPAREN = 4'd6;
  localparam logic [KIND_W-1:0] K_RPAREN = 4'd7;
  localparam logic [KIND_W-1:0] K_COMMA  = 4'd8;
  localparam logic [KIND_W-1:0] K_IDENT  = 4'd9;
  localparam logic [KIND_W-1:0] K_END    = 4'd10;
  localparam logic [KIND_W-1:0] K_ERROR  = 4'd11;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LETTER  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [ERR_W-1:0] ERR_LONG    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FPOS_W-1:0] start_pos;
    logic [FPOS_W-1:0] token_len;
    logic [ERR_W-1:0]  error_code;
  } tok_t;

  // One item's results: slot 0 pending run, slot 1 character token or
  // error, slot 2 end marker. Valid slots go out in slot order.
  localparam int SLOTS = 3;

  typedef struct packed {
    logic [SLOTS-1:0]       vld;
    tok_t [SLOTS-1:0]       tok;
  } grp_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- src/ect_front.sv -----
// Front end: classifies each character, tracks scan mode and position,
// and builds the group of tokens an item causes. Depends on ect_pkg.
`timescale 1ns / 1ps

module ect_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        in_has_char,
  input  logic        in_end_of_text,
  input  logic        q_full,
  output logic        q_push,
  output ect_pkg::grp_t q_grp
);
  import ect_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_DROP  = 2'd3;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  logic [1:0] mode_r, mode_nxt;
  pos_t       pos_r, pos_nxt;
  pos_t       start_r, start_nxt;

  logic              ch_digit, is_letter, is_space, is_punct;
  logic [KIND_W-1:0] punct_kind;
  logic              accept;
  grp_t              grp;

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind, input pos_t pos,
                                  input pos_t len, input logic [ERR_W-1:0] err);
    tok_t t;
    t.kind       = kind;
    t.start_pos  = FPOS_W'(pos);
    t.token_len  = FPOS_W'(len);
    t.error_code = err;
    return t;
  endfunction

  always_comb begin
    ch_digit  = (in_ch >= CH_0) && (in_ch <= CH_9);
    is_letter = ((in_ch >= CH_LA) && (in_ch <= CH_LZ)) ||
                ((in_ch >= CH_UA) && (in_ch <= CH_UZ));
    is_space  = (in_ch == CH_SPACE) || (in_ch == CH_TAB) ||
                (in_ch == CH_CR) || (in_ch == CH_LF);
    is_punct  = 1'b1;
    unique case (in_ch)
      CH_PLUS:   punct_kind = K_PLUS;
      CH_MINUS:  punct_kind = K_MINUS;
      CH_STAR:   punct_kind = K_STAR;
      CH_SLASH:  punct_kind = K_SLASH;
      CH_CARET:  punct_kind = K_CARET;
      CH_LPAREN: punct_kind = K_LPAREN;
      CH_RPAREN: punct_kind = K_RPAREN;
      CH_COMMA:  punct_kind = K_COMMA;
      default: begin
        punct_kind = K_ERROR;
        is_punct   = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    grp       = '0;
    if (mode_r == MODE_DROP) begin
      // drop everything up to the end of this expression
      if (in_end_of_text) begin
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
      end
    end else begin
      if (in_has_char) begin
        if (pos_r == POS_MAX) begin
          grp.vld[1] = 1'b1;
          grp.tok[1] = mk_tok(K_ERROR, pos_r, '0, ERR_LONG);
          mode_nxt   = MODE_DROP;
        end else begin
          if (mode_r == MODE_NUM && !ch_digit) begin
            if (is_letter) begin
              grp.vld[1] = 1'b1;
              grp.tok[1] = mk_tok(K_ERROR, pos_r, '0, ERR_LETTER);
              mode_nxt   = MODE_DROP;
            end else begin
              grp.vld[0] = 1'b1;
              grp.tok[0] = mk_tok(K_NUMBER, start_r, pos_r - start_r, ERR_NONE);
              mode_nxt   = MODE_IDLE;
            end
          end else if (mode_r == MODE_IDENT && !ch_digit && !is_letter) begin
            grp.vld[0] = 1'b1;
            grp.tok[0] = mk_tok(K_IDENT, start_r, pos_r - start_r, ERR_NONE);
            mode_nxt   = MODE_IDLE;
          end
          if (mode_nxt == MODE_IDLE) begin
            if (is_punct) begin
              grp.vld[1] = 1'b1;
              grp.tok[1] = mk_tok(punct_kind, pos_r, pos_t'(1), ERR_NONE);
            end else if (ch_digit) begin
              mode_nxt  = MODE_NUM;
              start_nxt = pos_r;
            end else if (is_letter) begin
              mode_nxt  = MODE_IDENT;
              start_nxt = pos_r;
            end else if (!is_space) begin
              grp.vld[1] = 1'b1;
              grp.tok[1] = mk_tok(K_ERROR, pos_r, '0, ERR_UNKNOWN);
              mode_nxt   = MODE_DROP;
            end
          end
          pos_nxt = pos_r + 1'b1;
        end
      end
      if (in_end_of_text) begin
        // a run still open here cannot have been flushed by this character
        if (mode_nxt == MODE_NUM || mode_nxt == MODE_IDENT) begin
          grp.vld[0] = 1'b1;
          grp.tok[0] = mk_tok((mode_nxt == MODE_NUM) ? K_NUMBER : K_IDENT,
                              start_nxt, pos_nxt - start_nxt, ERR_NONE);
        end
        if (mode_nxt != MODE_DROP) begin
          grp.vld[2] = 1'b1;
          grp.tok[2] = mk_tok(K_END, '0, '0, ERR_NONE);
        end
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
      end
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && (grp.vld != '0);
  assign q_grp   = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ----- src/ect_queue.sv -----
// Short queue of token groups between front and back end.
// Depends on ect_pkg.
`timescale 1ns / 1ps

module ect_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ect_pkg::grp_t wr_grp,
  output logic          full,
  input  logic          deq,
  output ect_pkg::grp_t rd_grp,
  output logic          nonempty
);
  import ect_pkg::*;

  grp_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_deq;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_deq   = deq && nonempty;
  assign rd_grp   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_deq) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_deq})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/ect_back.sv -----
// Back end: holds one token group in an output register and hands its
// valid tokens out one per pop, in slot order. Depends on ect_pkg.
`timescale 1ns / 1ps

module ect_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ect_pkg::grp_t                 q_grp,
  input  logic                          q_nonempty,
  output logic                          q_deq,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ect_pkg::KIND_W-1:0]    out_token_kind,
  output logic [ect_pkg::FPOS_W-1:0]    out_start_pos,
  output logic [ect_pkg::FPOS_W-1:0]    out_token_len,
  output logic [ect_pkg::ERR_W-1:0]     out_error_code,
  output logic                          out_last_of_item
);
  import ect_pkg::*;

  grp_t             grp_r;
  logic [SLOTS-1:0] mask_r, mask_nxt;
  logic [SLOTS-1:0] cur, rest;
  logic             take, load;
  tok_t             cur_tok;

  // lowest pending slot goes out first
  assign cur  = mask_r & (~mask_r + 1'b1);
  assign rest = mask_r & ~cur;
  assign take = out_pop && (mask_r != '0);
  assign load = q_nonempty && ((mask_r == '0) || (take && (rest == '0)));
  assign q_deq = load;

  always_comb begin
    if (mask_r[0]) begin
      cur_tok = grp_r.tok[0];
    end else if (mask_r[1]) begin
      cur_tok = grp_r.tok[1];
    end else begin
      cur_tok = grp_r.tok[2];
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (take) begin
      mask_nxt = rest;
    end
    if (load) begin
      mask_nxt = q_grp.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= q_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  assign out_empty        = (mask_r == '0);
  assign out_token_kind   = cur_tok.kind;
  assign out_start_pos    = cur_tok.start_pos;
  assign out_token_len    = cur_tok.token_len;
  assign out_error_code   = cur_tok.error_code;
  assign out_last_of_item = (rest == '0);

endmodule

// ----- src/expression_char_tokenizer.sv -----
// Top level of the expression character tokenizer: front end, group
// queue and back end. Depends on ect_pkg, ect_front, ect_queue, ect_back.
//
// Usage:
//   Input channel: one character per item (in_ch, in_has_char,
//   in_end_of_text), taken when in_push is high and in_full is low.
//   Result channel: tokens (kind, start position, length, error code,
//   last_of_item), shown while out_empty is low, taken with out_pop.
//   Timing: the front end decides an item in the cycle it is taken and
//   stores its tokens (up to three) as one group in a four-entry queue;
//   the back end loads a group into its output register once the output
//   is empty or its last token is popped. The first token of an item
//   shows after its group has passed through the queue and output register.
//   Throughput: one item per cycle while in_full is low; the result side
//   drains one token per cycle while out_pop is high.
//   Items that cause no token (spaces, dropped text) never enter the queue.
//   Stall: when out_pop stays low the output holds; the queue fills and
//   in_full rises once four groups wait behind the output register.
//   Reset (rst_n low, synchronous): scan mode idle, position zero, queue
//   and output empty; no clearing pass, the block takes items right away.
`timescale 1ns / 1ps

module expression_char_tokenizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_ch,
  input  logic                          in_has_char,
  input  logic                          in_end_of_text,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ect_pkg::KIND_W-1:0]    out_token_kind,
  output logic [ect_pkg::FPOS_W-1:0]    out_start_pos,
  output logic [ect_pkg::FPOS_W-1:0]    out_token_len,
  output logic [ect_pkg::ERR_W-1:0]     out_error_code,
  output logic                          out_last_of_item
);
  import ect_pkg::*;

  grp_t wr_grp, rd_grp;
  logic q_push, q_full, q_deq, q_nonempty;

  ect_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .in_has_char    (in_has_char),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_grp          (wr_grp)
  );

  ect_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_grp   (wr_grp),
    .full     (q_full),
    .deq      (q_deq),
    .rd_grp   (rd_grp),
    .nonempty (q_nonempty)
  );

  ect_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_grp            (rd_grp),
    .q_nonempty       (q_nonempty),
    .q_deq            (q_deq),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_start_pos    (out_start_pos),
    .out_token_len    (out_token_len),
    .out_error_code   (out_error_code),
    .out_last_of_item (out_last_of_item)
  );

endmodule

// ----- src/ect_checker.sv -----
// Port-level checks for the expression character tokenizer, bound to the
// top level. Depends on ect_pkg and expression_char_tokenizer.
`timescale 1ns / 1ps

module ect_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic [7:0]                    in_ch,
  input  logic                          in_has_char,
  input  logic                          in_end_of_text,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic [ect_pkg::KIND_W-1:0]    out_token_kind,
  input  logic [ect_pkg::FPOS_W-1:0]    out_start_pos,
  input  logic [ect_pkg::FPOS_W-1:0]    out_token_len,
  input  logic [ect_pkg::ERR_W-1:0]     out_error_code,
  input  logic                          out_last_of_item
);
  import ect_pkg::*;

  // reset leaves both sides open and nothing waiting
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("tokenizer not clear after reset");

  // a waiting token holds while the receiver stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_token_kind) &&
      $stable(out_start_pos) && $stable(out_token_len) &&
      $stable(out_error_code) && $stable(out_last_of_item))
    else $error("result changed while stalled");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_token_kind == K_ERROR |->
      out_token_len == '0 && out_error_code != ERR_NONE)
    else $error("malformed error token");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_token_kind == K_END |->
      out_start_pos == '0 && out_token_len == '0 && out_last_of_item)
    else $error("malformed end token");

  // single-character tokens are one character long and carry no error
  a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_token_kind != K_NUMBER && out_token_kind != K_IDENT &&
      out_token_kind != K_END && out_token_kind != K_ERROR |->
      out_token_len == FPOS_W'(1) && out_error_code == ERR_NONE)
    else $error("bad single-character token");

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (.*);
